/* src/pim_pkg.sv */
// ----------------------------------------------------------------------------
// pim_pkg
// Shared widths, stream bit positions and helpers for the pair mass pipeline.
// ----------------------------------------------------------------------------
package pim_pkg;

   localparam int MASS_W   = 31;
   localparam int MOM_W    = 32;
   localparam int RES_W    = 32;

   // energy radicand and root
   localparam int E_RAD_W  = 64;
   localparam int E_ROOT_W = 32;
   // mass radicand and root (root saturated to RES_W)
   localparam int M_RAD_W  = 66;
   localparam int M_ROOT_W = 33;

   localparam int REQ_DATA_W = 256;
   localparam int RSP_DATA_W = 104;

   // request field positions, lowest bit
   localparam int MASS_A_LSB = 0;
   localparam int PX_A_LSB   = 31;
   localparam int PY_A_LSB   = 63;
   localparam int PZ_A_LSB   = 95;
   localparam int MASS_B_LSB = 127;
   localparam int PX_B_LSB   = 158;
   localparam int PY_B_LSB   = 190;
   localparam int PZ_B_LSB   = 222;

   // magnitude of a signed 32-bit value
   function automatic logic [MOM_W-1:0] mag32(input logic [MOM_W-1:0] v);
      mag32 = v[MOM_W-1] ? (~v + MOM_W'(1)) : v;
   endfunction

   // magnitude of a signed 33-bit sum
   function automatic logic [MOM_W:0] mag33(input logic [MOM_W:0] v);
      mag33 = v[MOM_W] ? (~v + (MOM_W+1)'(1)) : v;
   endfunction

endpackage

/* src/pim_sqrt.sv */
// ----------------------------------------------------------------------------
// pim_sqrt
// Pipelined floor square root, one root bit resolved per register stage,
// with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module pim_sqrt #(
   parameter int IN_W   = pim_pkg::E_RAD_W,
   parameter int OUT_W  = pim_pkg::E_ROOT_W,
   parameter int SIDE_W = pim_pkg::M_RAD_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   in_radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [OUT_W-1:0]  out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int TW = 2 * OUT_W + 1;

   logic              valid_in [OUT_W+1];
   logic [TW-1:0]     rem_in   [OUT_W];
   logic [OUT_W-1:0]  root_in  [OUT_W+1];
   logic [SIDE_W-1:0] side_in  [OUT_W+1];

   assign valid_in[0] = in_valid;
   assign rem_in[0]   = TW'(in_radicand);
   assign root_in[0]  = '0;
   assign side_in[0]  = in_side;

   for (genvar k = 0; k < OUT_W; k++) begin : g_stage
      localparam int B = OUT_W - 1 - k;

      logic              valid_ff;
      logic [OUT_W-1:0]  root_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [TW-1:0]     trial;
      logic              take;

      // trial term 2*r*2^B + 2^(2B)
      assign trial = (TW'(root_in[k]) << (B + 1)) | (TW'(1) << (2 * B));
      assign take  = rem_in[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= valid_in[k];
         end
      end

      // resolve one root bit
      always_ff @(posedge clock) begin
         if (advance) begin
            root_ff <= take ? (root_in[k] | (OUT_W'(1) << B)) : root_in[k];
            side_ff <= side_in[k];
         end
      end

      // carry the remainder to the next bit; the last stage needs none
      if (k < OUT_W - 1) begin : g_rem
         logic [TW-1:0] rem_ff;

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff <= take ? (rem_in[k] - trial) : rem_in[k];
            end
         end

         assign rem_in[k+1] = rem_ff;
      end

      assign valid_in[k+1] = valid_ff;
      assign root_in[k+1]  = root_ff;
      assign side_in[k+1]  = side_ff;
   end

   assign out_valid = valid_in[OUT_W];
   assign out_root  = root_in[OUT_W];
   assign out_side  = side_in[OUT_W];

endmodule

/* src/pair_invariant_mass.sv */
// ----------------------------------------------------------------------------
// pair_invariant_mass
// Energies of two particles and the invariant mass of the pair.
// ----------------------------------------------------------------------------
// Each request on the req_ stream carries two particles (rest mass and three
// signed momentum components, fixed point). Each response on the rsp_ stream
// carries both energies sqrt(m^2+|p|^2), the invariant mass
// sqrt((Ea+Eb)^2-|pa+pb|^2), floored, and a flag set when the mass radicand
// is negative (the mass then reads zero). A mass above 32 bits saturates.
// The block is a 72-stage pipeline: squares, adder stages, a 32-stage root
// for the energies, the energy-sum square and subtract, a 33-stage root for
// the mass and an output register. One request is taken every clock while
// the response is not stalled. The whole pipeline moves as one: when the
// response is stalled, req_tready drops and every stage holds, so nothing is
// lost or repeated. Reset empties the pipeline by clearing the valid bits; no
// state survives between requests.
// ----------------------------------------------------------------------------
module pair_invariant_mass (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mass_a[30:0] px_a[62:31] py_a[94:63] pz_a[126:95] mass_b[157:127]
   // px_b[189:158] py_b[221:190] pz_b[253:222], zero pad above
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // invariant_mass[31:0] energy_a[63:32] energy_b[95:64] unphysical[96],
   // zero pad above
   output logic [103:0] rsp_tdata
);

   localparam int MW = pim_pkg::MOM_W;
   localparam int SW = pim_pkg::M_RAD_W - pim_pkg::M_ROOT_W;

   logic advance;

   // unpacked request fields
   logic [pim_pkg::MASS_W-1:0] mass_a, mass_b;
   logic [MW-1:0] px_a, py_a, pz_a, px_b, py_b, pz_b;

   assign mass_a = req_tdata[pim_pkg::MASS_A_LSB +: pim_pkg::MASS_W];
   assign px_a   = req_tdata[pim_pkg::PX_A_LSB +: MW];
   assign py_a   = req_tdata[pim_pkg::PY_A_LSB +: MW];
   assign pz_a   = req_tdata[pim_pkg::PZ_A_LSB +: MW];
   assign mass_b = req_tdata[pim_pkg::MASS_B_LSB +: pim_pkg::MASS_W];
   assign px_b   = req_tdata[pim_pkg::PX_B_LSB +: MW];
   assign py_b   = req_tdata[pim_pkg::PY_B_LSB +: MW];
   assign pz_b   = req_tdata[pim_pkg::PZ_B_LSB +: MW];

   // stage 1: squares and momentum sums
   logic          s1_valid_ff;
   logic [63:0]   sq_ff [8];
   logic [MW:0]   pm_ff [3];
   logic [MW:0]   sum_x, sum_y, sum_z;

   assign sum_x = {px_a[MW-1], px_a} + {px_b[MW-1], px_b};
   assign sum_y = {py_a[MW-1], py_a} + {py_b[MW-1], py_b};
   assign sum_z = {pz_a[MW-1], pz_a} + {pz_b[MW-1], pz_b};

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff[0] <= 64'(mass_a) * 64'(mass_a);
         sq_ff[1] <= 64'(pim_pkg::mag32(px_a)) * 64'(pim_pkg::mag32(px_a));
         sq_ff[2] <= 64'(pim_pkg::mag32(py_a)) * 64'(pim_pkg::mag32(py_a));
         sq_ff[3] <= 64'(pim_pkg::mag32(pz_a)) * 64'(pim_pkg::mag32(pz_a));
         sq_ff[4] <= 64'(mass_b) * 64'(mass_b);
         sq_ff[5] <= 64'(pim_pkg::mag32(px_b)) * 64'(pim_pkg::mag32(px_b));
         sq_ff[6] <= 64'(pim_pkg::mag32(py_b)) * 64'(pim_pkg::mag32(py_b));
         sq_ff[7] <= 64'(pim_pkg::mag32(pz_b)) * 64'(pim_pkg::mag32(pz_b));
         pm_ff[0] <= pim_pkg::mag33(sum_x);
         pm_ff[1] <= pim_pkg::mag33(sum_y);
         pm_ff[2] <= pim_pkg::mag33(sum_z);
      end
   end

   // stage 2: partial energy sums, momentum-sum squares
   logic          s2_valid_ff;
   logic [64:0]   part_ff [4];
   logic [65:0]   pq_ff   [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         part_ff[0] <= 65'(sq_ff[0]) + 65'(sq_ff[1]);
         part_ff[1] <= 65'(sq_ff[2]) + 65'(sq_ff[3]);
         part_ff[2] <= 65'(sq_ff[4]) + 65'(sq_ff[5]);
         part_ff[3] <= 65'(sq_ff[6]) + 65'(sq_ff[7]);
         for (int i = 0; i < 3; i++) begin
            pq_ff[i] <= 66'(pm_ff[i]) * 66'(pm_ff[i]);
         end
      end
   end

   // stage 3: energy radicands (always below 2^64) and |pa+pb|^2
   logic                        s3_valid_ff;
   logic [pim_pkg::E_RAD_W-1:0] rad_a_ff, rad_b_ff;
   logic [pim_pkg::M_RAD_W-1:0] p2_ff;
   logic [64:0]                 rad_a_sum, rad_b_sum;

   assign rad_a_sum = part_ff[0] + part_ff[1];
   assign rad_b_sum = part_ff[2] + part_ff[3];

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_a_ff <= rad_a_sum[pim_pkg::E_RAD_W-1:0];
         rad_b_ff <= rad_b_sum[pim_pkg::E_RAD_W-1:0];
         p2_ff    <= pq_ff[0] + pq_ff[1] + pq_ff[2];
      end
   end

   // energy roots; |pa+pb|^2 rides along, split over both lanes
   logic                         ea_valid, eb_valid;
   logic [pim_pkg::E_ROOT_W-1:0] ea_root, eb_root;
   logic [SW-1:0]                p2_hi;
   logic [pim_pkg::M_ROOT_W-1:0] p2_lo;

   pim_sqrt #(
      .IN_W   (pim_pkg::E_RAD_W),
      .OUT_W  (pim_pkg::E_ROOT_W),
      .SIDE_W (SW)
   ) u_sqrt_ea (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s3_valid_ff),
      .in_radicand (rad_a_ff),
      .in_side     (p2_ff[pim_pkg::M_RAD_W-1:pim_pkg::M_ROOT_W]),
      .out_valid   (ea_valid),
      .out_root    (ea_root),
      .out_side    (p2_hi)
   );

   pim_sqrt #(
      .IN_W   (pim_pkg::E_RAD_W),
      .OUT_W  (pim_pkg::E_ROOT_W),
      .SIDE_W (pim_pkg::M_ROOT_W)
   ) u_sqrt_eb (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s3_valid_ff),
      .in_radicand (rad_b_ff),
      .in_side     (p2_ff[pim_pkg::M_ROOT_W-1:0]),
      .out_valid   (eb_valid),
      .out_root    (eb_root),
      .out_side    (p2_lo)
   );

   // stage 4: energy sum
   logic                         s4_valid_ff;
   logic [pim_pkg::E_ROOT_W:0]   esum_ff;
   logic [pim_pkg::E_ROOT_W-1:0] ea4_ff, eb4_ff, ea5_ff, eb5_ff, ea6_ff, eb6_ff;
   logic [pim_pkg::M_RAD_W-1:0]  p2_4_ff, p2_5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         esum_ff <= (pim_pkg::E_ROOT_W+1)'(ea_root) + (pim_pkg::E_ROOT_W+1)'(eb_root);
         ea4_ff  <= ea_root;
         eb4_ff  <= eb_root;
         p2_4_ff <= {p2_hi, p2_lo};
      end
   end

   // stage 5: square of the energy sum
   logic                        s5_valid_ff;
   logic [pim_pkg::M_RAD_W-1:0] e2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         e2_ff   <= pim_pkg::M_RAD_W'(esum_ff) * pim_pkg::M_RAD_W'(esum_ff);
         ea5_ff  <= ea4_ff;
         eb5_ff  <= eb4_ff;
         p2_5_ff <= p2_4_ff;
      end
   end

   // stage 6: mass radicand, zero and flagged when negative
   logic                        s6_valid_ff;
   logic                        neg_ff;
   logic [pim_pkg::M_RAD_W-1:0] mrad_ff;
   logic                        neg;

   assign neg = e2_ff < p2_5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff  <= neg;
         mrad_ff <= neg ? '0 : (e2_ff - p2_5_ff);
         ea6_ff  <= ea5_ff;
         eb6_ff  <= eb5_ff;
      end
   end

   // mass root; energies and flag ride along
   localparam int MS_W = 2 * pim_pkg::E_ROOT_W + 1;

   logic                         m_valid;
   logic [pim_pkg::M_ROOT_W-1:0] m_root;
   logic [MS_W-1:0]              m_side;

   pim_sqrt #(
      .IN_W   (pim_pkg::M_RAD_W),
      .OUT_W  (pim_pkg::M_ROOT_W),
      .SIDE_W (MS_W)
   ) u_sqrt_m (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s6_valid_ff),
      .in_radicand (mrad_ff),
      .in_side     ({neg_ff, eb6_ff, ea6_ff}),
      .out_valid   (m_valid),
      .out_root    (m_root),
      .out_side    (m_side)
   );

   // stage 7: saturate into the response register
   logic                      rsp_valid_ff;
   logic [pim_pkg::RES_W-1:0] mass_ff;
   logic [MS_W-1:0]           side_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         mass_ff <= m_root[pim_pkg::M_ROOT_W-1] ? '1 : m_root[pim_pkg::RES_W-1:0];
         side_ff <= m_side;
      end
   end

   // valid bits of the pipeline stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= ea_valid & eb_valid;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= m_valid;
      end
   end

   // hold every stage while the response waits
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, side_ff, mass_ff};

endmodule
